// File: rtl/core/va_pkg.sv
// Package for the vector angle unit: angle constants, the arctangent step
// table and the types that travel along the CORDIC cell chain.
// No dependencies.
`default_nettype none

package va_pkg;

  // Width of the vector magnitudes inside the chain (room for CORDIC growth).
  localparam int unsigned XY_W = 64;
  // Width of the internal angle, radians with 32 fraction bits, signed.
  localparam int unsigned ANG_W = 36;
  // Fraction bits of the internal angle.
  localparam int unsigned ANG_FRAC = 32;
  // Magnitudes are placed so that the largest lands just below bit 60.
  localparam int unsigned MAG_TOP = 60;

  localparam logic signed [ANG_W-1:0] PI_Q32            = 36'sd13493037705;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32       = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] THREE_HALF_PI_Q32 = 36'sd20239556557;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q32        = 36'sd26986075409;

  // Fixed angle for vectors on an axis and for the zero vector.
  typedef enum logic [1:0] {
    FIX_ZERO,
    FIX_HALF_PI,
    FIX_PI,
    FIX_THREE_HALF_PI
  } va_fix_e;

  // Side information that follows a vector down the chain.
  typedef struct packed {
    logic    fixed;
    va_fix_e fix_sel;
    logic    dx_neg;
    logic    dy_neg;
  } va_tag_t;

  // Working vector and accumulated angle of one CORDIC cell.
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } va_vec_t;

  // Arctangent of 2^-idx in radians with 32 fraction bits.
  function automatic logic signed [ANG_W-1:0] atan_q32(input int unsigned idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      0:  val = 36'sd3373259426;
      1:  val = 36'sd1991351318;
      2:  val = 36'sd1052175346;
      3:  val = 36'sd534100635;
      4:  val = 36'sd268086748;
      5:  val = 36'sd134174063;
      6:  val = 36'sd67103403;
      7:  val = 36'sd33553749;
      8:  val = 36'sd16777131;
      9:  val = 36'sd8388597;
      10: val = 36'sd4194303;
      default: val = (idx > ANG_FRAC) ? '0 : ANG_W'(64'd1 << (ANG_FRAC - idx));
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/va_if.sv
// Stream interfaces of the vector angle unit: the point-pair input channel
// and the angle output channel. No dependencies.
`default_nettype none

interface va_in_if #(
  parameter int CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] from_x;
  logic signed [CoordBits-1:0] from_y;
  logic signed [CoordBits-1:0] to_x;
  logic signed [CoordBits-1:0] to_y;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  input ready);
  modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
                output ready);
endinterface

interface va_out_if #(
  parameter int AngleFracBits = 13
);
  logic                     valid;
  logic                     ready;
  logic [AngleFracBits+2:0] direction;

  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

`default_nettype wire

// File: rtl/core/vector_angle_atan2_unit.sv
// Vector angle unit: full-circle direction of the vector between two points
// through a chain of CORDIC vectoring cells.
// Depends on va_pkg, va_if, va_prep, va_cell and va_post.
//
// Usage:
//   in_i carries a beat of four signed coordinates (from_x, from_y, to_x,
//   to_y); out_o returns one beat per input beat, the angle of the vector
//   from the start point to the end point as unsigned Q3.ANGLE_FRAC_BITS
//   radians in [0, 2*pi). Beats leave in the order they entered.
//   From acceptance to the output register a beat passes one front cell,
//   ANGLE_FRAC_BITS + 3 CORDIC cells and two back-end cells. Throughput is
//   one beat per cycle while the chain advances; every CORDIC cell does one
//   micro-rotation and hands its vector on each cycle that the chain advances.
//   The whole chain moves together: it advances whenever the output
//   register is empty or being taken. While the receiver holds ready low
//   with a result waiting, the chain freezes and in_i.ready drops; nothing
//   is lost or repeated. Empty slots travel along with the chain and are
//   not squeezed out during a stall.
//   Reset clears every valid flag of the chain, so out_o.valid is low and
//   in_i.ready is high right after reset. There is no configuration.
`default_nettype none

module vector_angle_atan2_unit #(
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  va_in_if.sink    in_i,
  va_out_if.source out_o
);
  import va_pkg::*;

  localparam int unsigned Iters = ANGLE_FRAC_BITS + 3;

  logic    adv;
  logic    pipe_valid [Iters+1];
  va_tag_t pipe_tag   [Iters+1];
  va_vec_t pipe_vec   [Iters+1];

  // The chain steps when the output register can take a beat.
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  va_prep #(
    .CoordBits (COORD_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_i.valid),
    .from_x_i (in_i.from_x),
    .from_y_i (in_i.from_y),
    .to_x_i   (in_i.to_x),
    .to_y_i   (in_i.to_y),
    .valid_o  (pipe_valid[0]),
    .tag_o    (pipe_tag[0]),
    .vec_o    (pipe_vec[0])
  );

  // Row of CORDIC cells, one shift amount each.
  for (genvar k = 0; k < Iters; k++) begin : g_cell
    va_cell #(
      .Stage (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (pipe_valid[k]),
      .tag_i   (pipe_tag[k]),
      .vec_i   (pipe_vec[k]),
      .valid_o (pipe_valid[k+1]),
      .tag_o   (pipe_tag[k+1]),
      .vec_o   (pipe_vec[k+1])
    );
  end

  va_post #(
    .AngleFracBits (ANGLE_FRAC_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (pipe_valid[Iters]),
    .tag_i       (pipe_tag[Iters]),
    .z_i         (pipe_vec[Iters].z),
    .valid_o     (out_o.valid),
    .direction_o (out_o.direction)
  );

`ifndef SYNTHESIS
  // A zero vector must be routed to the fixed-angle path as zero.
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.from_x == in_i.to_x && in_i.from_y == in_i.to_y)
    |=> (pipe_valid[0] && pipe_tag[0].fixed && pipe_tag[0].fix_sel == FIX_ZERO))
    else $error("zero vector not flagged as fixed angle");

  // A vector on the horizontal axis must also take the fixed-angle path.
  a_horizontal_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.from_y == in_i.to_y)
    |=> (pipe_valid[0] && pipe_tag[0].fixed))
    else $error("horizontal vector not flagged as fixed angle");

  // While stalled, the beat feeding the back end must not move.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(pipe_valid[Iters]) && $stable(pipe_vec[Iters].z)))
    else $error("chain moved during a stall");
`endif

endmodule

`default_nettype wire

// File: rtl/core/va_cell.sv
// One CORDIC vectoring cell: a single micro-rotation with a fixed shift,
// registered and handed to the next cell. Depends on va_pkg.
`default_nettype none

module va_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  va_pkg::va_tag_t  tag_i,
  input  va_pkg::va_vec_t  vec_i,
  output logic             valid_o,
  output va_pkg::va_tag_t  tag_o,
  output va_pkg::va_vec_t  vec_o
);
  import va_pkg::*;

  localparam logic signed [ANG_W-1:0] AtanStep = atan_q32(Stage);

  logic signed [XY_W-1:0] xs, ys;
  logic                   valid_q;
  va_tag_t                tag_q;
  va_vec_t                vec_d, vec_q;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    xs = vec_i.x >>> Stage;
    ys = vec_i.y >>> Stage;
    if (!vec_i.y[XY_W-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + AtanStep;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - AtanStep;
    end
  end

  // Beat-valid flag of this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload moves on with the chain.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_i;
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

// File: rtl/core/va_prep.sv
// Front cell of the vector angle unit: vector difference, axis and zero
// detection, and magnitudes scaled for the CORDIC chain. Depends on va_pkg.
`default_nettype none

module va_prep #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [CoordBits-1:0] from_x_i,
  input  logic signed [CoordBits-1:0] from_y_i,
  input  logic signed [CoordBits-1:0] to_x_i,
  input  logic signed [CoordBits-1:0] to_y_i,
  output logic                        valid_o,
  output va_pkg::va_tag_t             tag_o,
  output va_pkg::va_vec_t             vec_o
);
  import va_pkg::*;

  localparam int unsigned GuardShift = MAG_TOP - CoordBits;

  logic signed [CoordBits:0] dx, dy;
  logic        [CoordBits:0] ax, ay;
  logic                      valid_q;
  va_tag_t                   tag_d, tag_q;
  va_vec_t                   vec_d, vec_q;

  // Difference at one extra bit, then magnitudes and quadrant signs.
  always_comb begin
    dx = (CoordBits+1)'(to_x_i) - (CoordBits+1)'(from_x_i);
    dy = (CoordBits+1)'(to_y_i) - (CoordBits+1)'(from_y_i);
    ax = dx[CoordBits] ? $unsigned(-dx) : $unsigned(dx);
    ay = dy[CoordBits] ? $unsigned(-dy) : $unsigned(dy);

    tag_d.dx_neg = dx[CoordBits];
    tag_d.dy_neg = dy[CoordBits];
    tag_d.fixed  = (dx == '0) || (dy == '0);
    if (dx == '0) begin
      if (dy == '0) begin
        tag_d.fix_sel = FIX_ZERO;
      end else if (dy[CoordBits]) begin
        tag_d.fix_sel = FIX_THREE_HALF_PI;
      end else begin
        tag_d.fix_sel = FIX_HALF_PI;
      end
    end else begin
      tag_d.fix_sel = dx[CoordBits] ? FIX_PI : FIX_ZERO;
    end

    vec_d.x = $signed(XY_W'(ax) << GuardShift);
    vec_d.y = $signed(XY_W'(ay) << GuardShift);
    vec_d.z = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_d;
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

// File: rtl/core/va_post.sv
// Back end of the vector angle unit: clamp and quadrant placement in one
// cell, rounding and full-circle wrap into the output register in the next.
// Depends on va_pkg.
`default_nettype none

module va_post #(
  parameter int unsigned AngleFracBits = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  va_pkg::va_tag_t                tag_i,
  input  logic signed [va_pkg::ANG_W-1:0] z_i,
  output logic                           valid_o,
  output logic [AngleFracBits+2:0]       direction_o
);
  import va_pkg::*;

  localparam int unsigned OutW       = AngleFracBits + 3;
  localparam int unsigned RoundShift = ANG_FRAC - AngleFracBits;
  localparam logic [ANG_W-1:0] RoundAdd = ANG_W'(64'd1 << (RoundShift - 1));
  localparam logic [ANG_W-1:0] FullCode =
    ANG_W'((64'(TWO_PI_Q32) + 64'(RoundAdd)) >> RoundShift);

  logic signed [ANG_W-1:0] a, ang_d, ang_q;
  logic                    valid_a_q, valid_q;
  logic        [ANG_W-1:0] sum, r_wide;
  logic        [OutW-1:0]  dir_d, dir_q;

  // Clamp the first-quadrant angle and place it in its quadrant.
  always_comb begin
    if (z_i[ANG_W-1]) begin
      a = '0;
    end else if (z_i > HALF_PI_Q32) begin
      a = HALF_PI_Q32;
    end else begin
      a = z_i;
    end

    if (tag_i.fixed) begin
      case (tag_i.fix_sel)
        FIX_ZERO:          ang_d = '0;
        FIX_HALF_PI:       ang_d = HALF_PI_Q32;
        FIX_PI:            ang_d = PI_Q32;
        FIX_THREE_HALF_PI: ang_d = THREE_HALF_PI_Q32;
        default:           ang_d = '0;
      endcase
    end else if (!tag_i.dx_neg && !tag_i.dy_neg) begin
      ang_d = a;
    end else if (tag_i.dx_neg && !tag_i.dy_neg) begin
      ang_d = PI_Q32 - a;
    end else if (tag_i.dx_neg) begin
      ang_d = PI_Q32 + a;
    end else begin
      ang_d = TWO_PI_Q32 - a;
    end
  end

  // Round half up to the output grid; a full turn wraps to zero.
  always_comb begin
    sum    = $unsigned(ang_q) + RoundAdd;
    r_wide = sum >> RoundShift;
    dir_d  = (r_wide >= FullCode) ? '0 : r_wide[OutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_q   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
      dir_q <= dir_d;
    end
  end

  assign valid_o     = valid_q;
  assign direction_o = dir_q;

endmodule

`default_nettype wire
